// File: rtl/sha1bh_pkg.sv
`timescale 1ns / 1ps

package sha1bh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [6:0]  round_t;
  typedef logic [3:0]  wpos_t;
  typedef logic [2:0]  didx_t;

  localparam int unsigned ChainWords = 5;
  localparam int unsigned WinWords   = 16;

  localparam round_t RoundLast  = 7'd79;
  localparam round_t RoundSched = 7'd16;
  localparam wpos_t  PosLast    = 4'd15;
  localparam didx_t  DigLast    = 3'd4;

  localparam word_t InitValue [ChainWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the window and the round datapath.
  typedef struct packed {
    logic   iv_load;
    logic   win_load;
    logic   work_init;
    logic   round_step;
    logic   chain_add;
    round_t round;
  } ctl_t;

  function automatic word_t round_mix(round_t t, word_t x, word_t y, word_t z);
    word_t r;
    case (t) inside
      [7'd0:7'd19]:  r = (x & y) ^ (~x & z);
      [7'd40:7'd59]: r = (x & y) ^ (x & z) ^ (y & z);
      default:       r = x ^ y ^ z;
    endcase
    return r;
  endfunction

  function automatic word_t round_const(round_t t);
    word_t r;
    case (t) inside
      [7'd0:7'd19]:  r = K0;
      [7'd20:7'd39]: r = K1;
      [7'd40:7'd59]: r = K2;
      default:       r = K3;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sha1bh_if.sv
`timescale 1ns / 1ps

interface sha1bh_msg_if;
  import sha1bh_pkg::*;
  logic  valid;
  logic  ready;
  word_t message_word;
  logic  message_start;
  logic  message_final;

  modport source(output valid, output message_word, output message_start,
                 output message_final, input ready);
  modport sink(input valid, input message_word, input message_start,
               input message_final, output ready);
endinterface

interface sha1bh_dig_if;
  import sha1bh_pkg::*;
  logic  valid;
  logic  ready;
  word_t digest_word;
  logic  digest_last;

  modport source(output valid, output digest_word, output digest_last, input ready);
  modport sink(input valid, input digest_word, input digest_last, output ready);
endinterface

// File: rtl/sha1bh_sched.sv
`timescale 1ns / 1ps

module sha1bh_sched
  import sha1bh_pkg::*;
(
  input  logic  clk,
  input  ctl_t  ctl,
  input  word_t word,
  output word_t w_t
);

  // Oldest word at index 0; every round shifts by one word.
  word_t win [WinWords];
  word_t w_exp;
  word_t shift_in;

  always_comb begin
    w_exp = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_exp = {w_exp[30:0], w_exp[31]};
    w_t = (ctl.round < RoundSched) ? win[0] : w_exp;
    shift_in = ctl.win_load ? word : w_t;
  end

  always_ff @(posedge clk) begin
    if (ctl.win_load || ctl.round_step) begin
      for (int i = 0; i < WinWords - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[WinWords - 1] <= shift_in;
    end
  end

endmodule

// File: rtl/sha1bh_round.sv
`timescale 1ns / 1ps

module sha1bh_round
  import sha1bh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl,
  input  word_t w_t,
  input  didx_t dig_idx,
  output word_t dig_word
);

  word_t chain [ChainWords];
  word_t work  [ChainWords];
  word_t tmp;

  // One SHA-1 round: working word a is work[0], e is work[4].
  always_comb begin
    tmp = {work[0][26:0], work[0][31:27]}
        + round_mix(ctl.round, work[1], work[2], work[3])
        + work[4] + round_const(ctl.round) + w_t;
    dig_word = chain[dig_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain[i] <= InitValue[i];
        work[i]  <= '0;
      end
    end else begin
      if (ctl.iv_load) begin
        for (int i = 0; i < ChainWords; i++) chain[i] <= InitValue[i];
      end else if (ctl.chain_add) begin
        for (int i = 0; i < ChainWords; i++) chain[i] <= chain[i] + work[i];
      end
      if (ctl.work_init) begin
        for (int i = 0; i < ChainWords; i++) work[i] <= chain[i];
      end else if (ctl.round_step) begin
        work[0] <= tmp;
        work[1] <= work[0];
        work[2] <= {work[1][1:0], work[1][31:2]};
        work[3] <= work[2];
        work[4] <= work[3];
      end
    end
  end

endmodule

// File: rtl/sha1_block_hash_top.sv
`timescale 1ns / 1ps

// SHA-1 block hash engine.
// msg channel: one 32-bit big-endian word per handshake, sixteen words to a
// padded 512-bit block. message_start reloads the initial hash value and
// makes the word word 0 of a new block; message_final on a word asks for the
// digest once that word has been absorbed.
// dig channel: five words H0..H4 after a final word, digest_last on H4.
// The first fifteen words of a block are shifted into the window. The
// sixteenth word starts the compression: 80 rounds on one shared round adder,
// one round per cycle, then a fold of the result into the chaining value in
// ST_ADD. msg.ready is low during that time.
// After a final word the digest follows, one word per cycle while dig.ready
// is high; a stalled receiver holds the current digest word, and no new
// message word is taken until H4 is delivered.
// Reset (rst, synchronous) loads the standard initial value, clears the
// word position and returns the sequencer to idle.
module sha1_block_hash_top
  import sha1bh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sha1bh_msg_if.sink   msg,
  sha1bh_dig_if.source dig
);

  state_t state, state_next;
  wpos_t  pos;
  wpos_t  eff_pos;
  round_t round;
  didx_t  dig_idx;
  logic   final_pend;
  logic   accept;
  logic   block_done;
  ctl_t   ctl;
  word_t  w_t;

  assign accept     = msg.valid && msg.ready;
  assign eff_pos    = msg.message_start ? '0 : pos;
  assign block_done = accept && (eff_pos == PosLast);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (block_done) state_next = ST_ROUND;
        else if (accept && msg.message_final) state_next = ST_EMIT;
      end
      ST_ROUND: begin
        if (round == RoundLast) state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = final_pend ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (dig.ready && dig_idx == DigLast) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    msg.ready       = (state == ST_IDLE);
    dig.valid       = (state == ST_EMIT);
    dig.digest_last = (dig_idx == DigLast);
    ctl.iv_load     = accept && msg.message_start;
    ctl.win_load    = accept;
    ctl.work_init   = block_done;
    ctl.round_step  = (state == ST_ROUND);
    ctl.chain_add   = (state == ST_ADD);
    ctl.round       = round;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      round      <= '0;
      dig_idx    <= '0;
      final_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        final_pend <= msg.message_final;
        pos <= (msg.message_final || block_done) ? '0 : eff_pos + 4'd1;
      end
      if (state == ST_ROUND) begin
        round <= (round == RoundLast) ? '0 : round + 7'd1;
      end
      // Advance through H0..H4 as the receiver takes them.
      if (state == ST_EMIT && dig.ready) begin
        dig_idx <= (dig_idx == DigLast) ? '0 : dig_idx + 3'd1;
      end
    end
  end

  sha1bh_sched u_sched (
    .clk  (clk),
    .ctl  (ctl),
    .word (msg.message_word),
    .w_t  (w_t)
  );

  sha1bh_round u_round (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .w_t      (w_t),
    .dig_idx  (dig_idx),
    .dig_word (dig.digest_word)
  );

endmodule
